// ----- hw/rtl/prq_pkg.sv -----
`timescale 1ns / 1ps

package prq_pkg;

    localparam int ID_W             = 5;
    localparam int SLOT_COUNT_DEF   = 32;

    typedef enum logic [1:0] {
        OP_INSERT      = 2'd0,
        OP_REMOVE_HEAD = 2'd1,
        OP_REMOVE_SLOT = 2'd2,
        OP_QUERY       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_INS2
    } t_state;

    typedef struct packed {
        t_op              operation;
        logic [ID_W-1:0]  proc_id;
    } t_cmd;

    typedef struct packed {
        logic             removed_valid;
        logic [ID_W-1:0]  removed_id;
        logic             head_valid;
        logic [ID_W-1:0]  head_id;
        logic             op_error;
    } t_result;

endpackage

// ----- hw/rtl/prq_link_ram.sv -----
`timescale 1ns / 1ps

module prq_link_ram #(
    parameter int DEPTH = prq_pkg::SLOT_COUNT_DEF,
    parameter int AW    = $clog2(prq_pkg::SLOT_COUNT_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/prq_ctrl.sv -----
`timescale 1ns / 1ps

module prq_ctrl #(
    parameter int SLOT_COUNT = prq_pkg::SLOT_COUNT_DEF,
    parameter int SW         = $clog2(prq_pkg::SLOT_COUNT_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  prq_pkg::t_cmd     i_cmd,
    output prq_pkg::t_result  o_result,
    output logic              o_result_strobe,
    output logic [SW-1:0]     o_ram_raddr,
    output logic              o_next_we,
    output logic [SW-1:0]     o_next_waddr,
    output logic [SW-1:0]     o_next_wdata,
    output logic              o_prev_we,
    output logic [SW-1:0]     o_prev_waddr,
    output logic [SW-1:0]     o_prev_wdata,
    input  logic [SW-1:0]     i_next_rdata,
    input  logic [SW-1:0]     i_prev_rdata
);

    localparam int IDW = prq_pkg::ID_W;

    prq_pkg::t_state   r_state, n_state;
    logic [SW-1:0]     r_id, n_id;
    logic [SW-1:0]     r_tail, n_tail;
    logic [SW-1:0]     r_head, n_head;
    logic              r_nonempty, n_nonempty;
    logic [SLOT_COUNT-1:0] r_in_queue, n_in_queue;
    prq_pkg::t_result  r_res, n_res;
    logic              r_strobe, n_strobe;

    logic              accept;
    logic              id_ok;
    logic [SW-1:0]     cmd_id;
    logic              fin;
    logic              rem_valid;
    logic [SW-1:0]     rem_id;
    logic              err;

    assign accept = start && (r_state == prq_pkg::S_IDLE);
    assign id_ok  = 32'(i_cmd.proc_id) < SLOT_COUNT;
    assign cmd_id = SW'(i_cmd.proc_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prq_pkg::S_IDLE;
            r_tail     <= '0;
            r_head     <= '0;
            r_nonempty <= 1'b0;
            r_in_queue <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tail     <= n_tail;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_in_queue <= n_in_queue;
            r_strobe   <= n_strobe;
        end
        r_id  <= n_id;
        r_res <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_id         = r_id;
        n_tail       = r_tail;
        n_head       = r_head;
        n_nonempty   = r_nonempty;
        n_in_queue   = r_in_queue;
        o_ram_raddr  = r_head;
        o_next_we    = 1'b0;
        o_next_waddr = '0;
        o_next_wdata = '0;
        o_prev_we    = 1'b0;
        o_prev_waddr = '0;
        o_prev_wdata = '0;
        fin          = 1'b0;
        rem_valid    = 1'b0;
        rem_id       = '0;
        err          = 1'b0;

        case (r_state)
            prq_pkg::S_IDLE: begin
                if (accept) begin
                    n_id = cmd_id;
                    case (i_cmd.operation)
                        prq_pkg::OP_INSERT: begin
                            if (!id_ok) begin
                                fin = 1'b1;
                            end else if (r_in_queue[cmd_id]) begin
                                err = 1'b1;
                                fin = 1'b1;
                            end else if (!r_nonempty) begin
                                // A lone slot links to itself both ways.
                                o_next_we    = 1'b1;
                                o_next_waddr = cmd_id;
                                o_next_wdata = cmd_id;
                                o_prev_we    = 1'b1;
                                o_prev_waddr = cmd_id;
                                o_prev_wdata = cmd_id;
                                n_head       = cmd_id;
                                n_tail       = cmd_id;
                                n_nonempty   = 1'b1;
                                n_in_queue[cmd_id] = 1'b1;
                                fin          = 1'b1;
                            end else begin
                                o_next_we    = 1'b1;
                                o_next_waddr = cmd_id;
                                o_next_wdata = r_head;
                                o_prev_we    = 1'b1;
                                o_prev_waddr = r_head;
                                o_prev_wdata = cmd_id;
                                n_state      = prq_pkg::S_INS2;
                            end
                        end
                        prq_pkg::OP_REMOVE_HEAD: begin
                            if (r_nonempty) begin
                                o_ram_raddr = r_head;
                                n_id        = r_head;
                                n_state     = prq_pkg::S_READ;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        prq_pkg::OP_REMOVE_SLOT: begin
                            if (id_ok && r_nonempty && r_in_queue[cmd_id]) begin
                                o_ram_raddr = cmd_id;
                                n_state     = prq_pkg::S_READ;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            prq_pkg::S_INS2: begin
                o_next_we    = 1'b1;
                o_next_waddr = r_tail;
                o_next_wdata = r_id;
                o_prev_we    = 1'b1;
                o_prev_waddr = r_id;
                o_prev_wdata = r_tail;
                n_tail       = r_id;
                n_in_queue[r_id] = 1'b1;
                fin          = 1'b1;
                n_state      = prq_pkg::S_IDLE;
            end
            prq_pkg::S_READ: begin
                rem_valid = 1'b1;
                rem_id    = r_id;
                n_in_queue[r_id] = 1'b0;
                if (i_next_rdata == r_id) begin
                    // The slot was the only member, so the ring collapses.
                    n_nonempty = 1'b0;
                    n_tail     = '0;
                end else begin
                    if (r_id == r_tail) begin
                        n_tail = i_prev_rdata;
                    end
                    if (r_id == r_head) begin
                        n_head = i_next_rdata;
                    end
                    o_next_we    = 1'b1;
                    o_next_waddr = i_prev_rdata;
                    o_next_wdata = i_next_rdata;
                    o_prev_we    = 1'b1;
                    o_prev_waddr = i_next_rdata;
                    o_prev_wdata = i_prev_rdata;
                end
                fin     = 1'b1;
                n_state = prq_pkg::S_IDLE;
            end
            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase

        n_strobe = fin;
        n_res    = r_res;
        if (fin) begin
            n_res.removed_valid = rem_valid;
            n_res.removed_id    = IDW'(rem_id);
            n_res.head_valid    = n_nonempty;
            n_res.head_id       = n_nonempty ? IDW'(n_head) : '0;
            n_res.op_error      = err;
        end
    end

    assign busy            = (r_state != prq_pkg::S_IDLE);
    assign o_result        = r_res;
    assign o_result_strobe = r_strobe;

    // The result transfer always falls in a cycle where a new command can be taken.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == prq_pkg::S_IDLE))
        else $error("result strobe while busy");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_res.head_valid == r_nonempty))
        else $error("reported head validity disagrees with queue state");

    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !(r_res.removed_valid && r_res.op_error))
        else $error("removal and error reported together");

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_nonempty |-> (r_in_queue == '0))
        else $error("membership mark set while queue is empty");

    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_strobe || busy))
        else $error("accepted command neither finished nor in progress");

endmodule

// ----- hw/rtl/process_queue_with_removal_core.sv -----
`timescale 1ns / 1ps

// FIFO of process slot numbers held as a circular doubly linked list.
// Command channel: i_cmd carries operation and proc_id; a command transfers at
// a rising edge where start is high and busy is low.
// Result channel: o_result is valid for exactly one cycle, flagged by
// o_result_strobe, and the transfer happens at the edge that ends that cycle.
// The receiver cannot hold a result off, and none is ever dropped.
// Query, rejected inserts, inserts into an empty queue and removals that find
// nothing strobe in the cycle after the command transfer. Inserts into a
// non-empty queue and successful removals pass through a second state first
// (S_INS2 or S_READ), needed because each link memory has a registered read
// (removals) or a single write port (inserts).
// busy is low again in the strobe cycle, so a new command may transfer there.
// Reset (synchronous, active low) empties the queue and clears all membership
// marks at once; the link memories are not cleared, as a link is only read
// after it has been written.
module process_queue_with_removal_core #(
    parameter int SLOT_COUNT = prq_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  prq_pkg::t_cmd     i_cmd,
    output prq_pkg::t_result  o_result,
    output logic              o_result_strobe
);

    localparam int SW = $clog2(SLOT_COUNT);

    logic [SW-1:0] ram_raddr;
    logic          next_we, prev_we;
    logic [SW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [SW-1:0] next_rdata, prev_rdata;

    prq_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe),
        .o_ram_raddr     (ram_raddr),
        .o_next_we       (next_we),
        .o_next_waddr    (next_waddr),
        .o_next_wdata    (next_wdata),
        .o_prev_we       (prev_we),
        .o_prev_waddr    (prev_waddr),
        .o_prev_wdata    (prev_wdata),
        .i_next_rdata    (next_rdata),
        .i_prev_rdata    (prev_rdata)
    );

    prq_link_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (SW)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (next_rdata)
    );

    prq_link_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (SW)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (prev_rdata)
    );

endmodule
